>>> src/rdj_pkg.sv
`default_nettype none
package rdj_pkg;

  localparam int ACC_BITS_DEFAULT = 32;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_REVERSE     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SENSITIVITY = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPAWN       = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IDLE_WINDOW = 3'd4;

  localparam logic [4:0]  SENSITIVITY_RESET = 5'd2;
  localparam logic [7:0]  SPAWN_RESET       = 8'd128;
  localparam logic [7:0]  OFFSET_RESET      = 8'd0;
  localparam logic [15:0] IDLE_WINDOW_RESET = 16'd90;

  // Active-low joystick bits.
  localparam logic [7:0] JOY_LEFT  = 8'h01;
  localparam logic [7:0] JOY_RIGHT = 8'h02;
  localparam logic [7:0] JOY_UP    = 8'h04;
  localparam logic [7:0] JOY_DOWN  = 8'h08;
  localparam logic [7:0] JOY_FIRE  = 8'h10;
  localparam logic [7:0] JOY_IDLE  = 8'hFF;

  // Bits to clear for each compass sector, starting at up and going clockwise.
  function automatic logic [7:0] sector_clear(input logic [2:0] sector);
    logic [7:0] bits;
    case (sector)
      3'd0: bits = JOY_UP;
      3'd1: bits = JOY_UP | JOY_RIGHT;
      3'd2: bits = JOY_RIGHT;
      3'd3: bits = JOY_DOWN | JOY_RIGHT;
      3'd4: bits = JOY_DOWN;
      3'd5: bits = JOY_DOWN | JOY_LEFT;
      3'd6: bits = JOY_LEFT;
      3'd7: bits = JOY_UP | JOY_LEFT;
      default: bits = 8'h00;
    endcase
    return bits;
  endfunction

endpackage
`default_nettype wire

>>> src/rdj_if.sv
`default_nettype none
interface rdj_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  dial_count;
  logic [31:0] time_ms;
  logic        fire_pressed;
  logic        game_running;

  modport source (output valid, output dial_count, output time_ms,
                  output fire_pressed, output game_running, input ready);
  modport sink (input valid, input dial_count, input time_ms,
                input fire_pressed, input game_running, output ready);
endinterface

interface rdj_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] port_value;
  logic       steering;

  modport source (output valid, output port_value, output steering, input ready);
  modport sink (input valid, input port_value, input steering, output ready);
endinterface
`default_nettype wire

>>> src/rotary_dial_to_eight_way_joystick.sv
`default_nettype none
// A poll that asserts a direction passes through the ABS, DIV and FIN states before its
// result is valid; a poll without a direction has its result valid in the cycle after.
// The bit-serial divider takes one quotient bit per cycle; a new poll is taken only once
// the previous result has been transferred. Reset (rst, synchronous, active high) returns
// the configuration registers to their defaults and clears the dial history, the turn
// accumulator and the armed flag.
module rotary_dial_to_eight_way_joystick #(
  parameter int ACCUMULATOR_BITS = rdj_pkg::ACC_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               wr_en,
  input  wire logic [rdj_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  wire logic [rdj_pkg::CFG_DATA_BITS-1:0]  wr_data,
  rdj_in_if.sink                                  dial,
  rdj_out_if.source                               joy
);
  import rdj_pkg::*;

  localparam int CNT_BITS = $clog2(ACCUMULATOR_BITS);
  localparam logic [CNT_BITS-1:0] LAST_BIT = CNT_BITS'(ACCUMULATOR_BITS - 1);

  typedef enum logic [2:0] {
    IDLE,
    ABS,
    DIV,
    FIN,
    OUT
  } state_t;

  // Configuration registers.
  logic        reverse_direction;
  logic [4:0]  sensitivity;
  logic [7:0]  spawn_position;
  logic [7:0]  dial_offset;
  logic [15:0] idle_window_ms;

  // Tracking state.
  state_t                      state;
  logic [7:0]                  previous_count;
  logic                        primed;
  logic [ACCUMULATOR_BITS-1:0] turn_accumulator;
  logic                        armed;
  logic [31:0]                 last_turn_time;

  // Divider working registers.
  logic [ACCUMULATOR_BITS-1:0] dividend;
  logic [4:0]                  remainder;
  logic [7:0]                  quotient;
  logic                        negative;
  logic [CNT_BITS-1:0]         bit_cnt;
  logic                        fire_hold;

  // Result registers.
  logic [7:0] port_value;
  logic       steering;

  // Step from the previous count, as a signed 8-bit difference.
  logic [7:0]                  raw_step;
  logic                        step_nonzero;
  logic [ACCUMULATOR_BITS-1:0] step_ext;
  logic [ACCUMULATOR_BITS-1:0] accumulator_next;
  logic [31:0]                 elapsed;
  logic                        steer_now;
  logic                        fire_now;

  always_comb begin
    raw_step         = primed ? (dial.dial_count - previous_count) : 8'd0;
    step_nonzero     = (raw_step != 8'd0);
    step_ext         = ACCUMULATOR_BITS'(signed'(raw_step));
    accumulator_next = reverse_direction ? (turn_accumulator - step_ext)
                                         : (turn_accumulator + step_ext);
    elapsed          = dial.time_ms - last_turn_time;
    // A step restamps the time, so a poll with a step steers whatever the elapsed time.
    steer_now        = step_nonzero ||
                       (armed && (elapsed <= {16'd0, idle_window_ms}));
    fire_now         = dial.fire_pressed && dial.game_running;
  end

  // One restoring-division step: bring down the next dividend bit and try
  // to subtract the divisor. A zero sensitivity divides by one.
  logic [4:0] divisor;
  logic [5:0] partial;
  logic [6:0] trial;
  logic       quot_bit;

  always_comb begin
    divisor  = (sensitivity == 5'd0) ? 5'd1 : sensitivity;
    partial  = {remainder, dividend[ACCUMULATOR_BITS-1]};
    trial    = {1'b0, partial} - {2'b00, divisor};
    quot_bit = !trial[6];
  end

  // Final mapping from the low quotient byte to a compass sector.
  logic [7:0] quot_signed;
  logic [7:0] position;
  logic [8:0] rounded;
  logic [7:0] dir_port;

  always_comb begin
    quot_signed = negative ? (8'd0 - quotient) : quotient;
    position    = quot_signed + spawn_position + dial_offset;
    rounded     = {1'b0, position} + 9'd16;
    dir_port    = JOY_IDLE & ~sector_clear(rounded[7:5]);
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_direction <= 1'b0;
      sensitivity       <= SENSITIVITY_RESET;
      spawn_position    <= SPAWN_RESET;
      dial_offset       <= OFFSET_RESET;
      idle_window_ms    <= IDLE_WINDOW_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_REVERSE:     reverse_direction <= wr_data[0];
        REG_SENSITIVITY: sensitivity       <= wr_data[4:0];
        REG_SPAWN:       spawn_position    <= wr_data[7:0];
        REG_OFFSET:      dial_offset       <= wr_data[7:0];
        REG_IDLE_WINDOW: idle_window_ms    <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer: take a poll, update the dial state, and when a direction is due
  // run the divider over the magnitude of the accumulator one bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= IDLE;
      previous_count   <= 8'd0;
      primed           <= 1'b0;
      turn_accumulator <= '0;
      armed            <= 1'b0;
      last_turn_time   <= 32'd0;
    end else begin
      case (state)
        IDLE: begin
          if (dial.valid) begin
            previous_count <= dial.dial_count;
            primed         <= 1'b1;
            fire_hold      <= fire_now;
            if (step_nonzero) begin
              turn_accumulator <= accumulator_next;
              armed            <= 1'b1;
              last_turn_time   <= dial.time_ms;
            end
            if (steer_now) begin
              state <= ABS;
            end else begin
              port_value <= fire_now ? (JOY_IDLE & ~JOY_FIRE) : JOY_IDLE;
              steering   <= 1'b0;
              state      <= OUT;
            end
          end
        end
        ABS: begin
          // Divide the magnitude and fix the sign afterwards: this truncates
          // toward zero.
          negative  <= turn_accumulator[ACCUMULATOR_BITS-1];
          dividend  <= turn_accumulator[ACCUMULATOR_BITS-1] ? (~turn_accumulator + 1'b1)
                                                             : turn_accumulator;
          remainder <= 5'd0;
          quotient  <= 8'd0;
          bit_cnt   <= LAST_BIT;
          state     <= DIV;
        end
        DIV: begin
          remainder <= quot_bit ? trial[4:0] : partial[4:0];
          quotient  <= {quotient[6:0], quot_bit};
          dividend  <= {dividend[ACCUMULATOR_BITS-2:0], 1'b0};
          bit_cnt   <= bit_cnt - 1'b1;
          if (bit_cnt == '0) begin
            state <= FIN;
          end
        end
        FIN: begin
          port_value <= fire_hold ? (dir_port & ~JOY_FIRE) : dir_port;
          steering   <= 1'b1;
          state      <= OUT;
        end
        OUT: begin
          if (joy.ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign dial.ready     = (state == IDLE);
  assign joy.valid      = (state == OUT);
  assign joy.port_value = port_value;
  assign joy.steering   = steering;

endmodule
`default_nettype wire

>>> src/rdj_checker.sv
`default_nettype none
module rdj_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] port_value,
  input wire logic       steering
);

  // A pending result is held until it is transferred.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // The block never takes a poll while a result is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // After a poll is taken, no further poll is taken in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second poll taken back to back");

  // Unused high bits stay released.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> port_value[7:5] == 3'b111)
    else $error("unused joystick bits driven");

  // Without steering no direction bit is asserted; with it, at least one is.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (steering ? (port_value[3:0] != 4'hF) : (port_value[3:0] == 4'hF)))
    else $error("direction bits disagree with steering");

endmodule

bind rotary_dial_to_eight_way_joystick rdj_checker u_rdj_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (dial.valid),
  .in_ready   (dial.ready),
  .out_valid  (joy.valid),
  .out_ready  (joy.ready),
  .port_value (joy.port_value),
  .steering   (joy.steering)
);
`default_nettype wire

>>> tb/rotary_dial_to_eight_way_joystick_test.sv
`timescale 1ns / 1ps

module rotary_dial_to_eight_way_joystick_test;
  import rdj_pkg::*;

  // The block runs with its default accumulator width, so the turn count
  // wraps exactly where the behavior expects it to.
  localparam int ACC_BITS = ACC_BITS_DEFAULT;

  // Bits to clear for each compass sector, from up going clockwise.
  localparam logic [7:0] SECTOR_BITS [8] = '{
    JOY_UP, JOY_UP | JOY_RIGHT, JOY_RIGHT, JOY_DOWN | JOY_RIGHT,
    JOY_DOWN, JOY_DOWN | JOY_LEFT, JOY_LEFT, JOY_UP | JOY_LEFT
  };

  typedef struct {
    logic [7:0]  dial_count;
    logic [31:0] time_ms;
    logic        fire_pressed;
    logic        game_running;
  } poll_t;

  typedef struct {
    logic [7:0] port_value;
    logic       steering;
  } joy_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                      wr_en;
  logic [CFG_INDEX_BITS-1:0] wr_index;
  logic [CFG_DATA_BITS-1:0]  wr_data;

  rdj_in_if  dial_bus ();
  rdj_out_if joy_bus ();

  rotary_dial_to_eight_way_joystick #(
    .ACCUMULATOR_BITS(ACC_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .dial     (dial_bus),
    .joy      (joy_bus)
  );

  always #1 clk = ~clk;

  // Polls waiting to be sent and joystick bytes waiting to come back.
  poll_t poll_queue [$];
  joy_t  pending_joystick [$];
  int    mismatch_count = 0;

  // Our own copy of the registers, written alongside the block's.
  logic        cfg_reverse = 1'b0;
  logic [4:0]  cfg_sens    = SENSITIVITY_RESET;
  logic [7:0]  cfg_spawn   = SPAWN_RESET;
  logic [7:0]  cfg_offset  = OFFSET_RESET;
  logic [15:0] cfg_window  = IDLE_WINDOW_RESET;

  // Our own copy of the dial history and turn state.
  logic [7:0]          last_count = '0;
  logic                have_count = 1'b0;
  logic [ACC_BITS-1:0] turn_sum   = '0;
  logic                is_armed   = 1'b0;
  logic [31:0]         turn_stamp = '0;

  // Where the stimulus generator has left the dial and the clock.
  logic [7:0]  cur_count = '0;
  logic [31:0] cur_time  = '0;

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Works out the joystick byte for one accepted poll and advances the
  // turn state, the same way the block has to.
  task automatic steer_from_poll(input poll_t p);
    logic [7:0]  raw;
    int          step;
    int          delta;
    logic [31:0] elapsed;
    longint      turn_val;
    longint      divisor;
    longint      dial_pos;
    logic [8:0]  rounded;
    joy_t        res;
    step = 0;
    if (have_count) begin
      raw  = p.dial_count - last_count;
      step = int'($signed(raw));
    end
    last_count = p.dial_count;
    have_count = 1'b1;

    if (step != 0) begin
      delta      = cfg_reverse ? -step : step;
      turn_sum   = turn_sum + delta[ACC_BITS-1:0];
      is_armed   = 1'b1;
      turn_stamp = p.time_ms;
    end

    res.port_value = JOY_IDLE;
    res.steering   = 1'b0;
    elapsed = p.time_ms - turn_stamp;
    if (is_armed && elapsed <= {16'd0, cfg_window}) begin
      // The turn count is signed; the divide truncates toward zero, and a
      // zero sensitivity behaves as one.
      turn_val = longint'($signed(turn_sum));
      divisor  = (cfg_sens == 5'd0) ? 64'sd1 : longint'(cfg_sens);
      dial_pos = turn_val / divisor;
      dial_pos = dial_pos + longint'(cfg_spawn) + longint'(cfg_offset);
      // Sectors are 32 positions wide and centered, so shift by half of one.
      rounded = {1'b0, dial_pos[7:0]} + 9'd16;
      res.port_value = JOY_IDLE & ~SECTOR_BITS[rounded[7:5]];
      res.steering   = 1'b1;
    end
    if (p.fire_pressed && p.game_running)
      res.port_value = res.port_value & ~JOY_FIRE;
    pending_joystick.push_back(res);
  endtask

  task automatic check_joystick(input logic [7:0] port_value, input logic steering);
    joy_t want;
    if (pending_joystick.size() == 0) begin
      flag_mismatch($sformatf("joystick byte %h with no poll outstanding", port_value));
    end else begin
      want = pending_joystick.pop_front();
      if (port_value !== want.port_value)
        flag_mismatch($sformatf("port_value %h, wanted %h", port_value, want.port_value));
      if (steering !== want.steering)
        flag_mismatch($sformatf("steering %b, wanted %b", steering, want.steering));
    end
  endtask

  // Sender side. A gap is drawn at random for every poll; from time
  // to time the sender switches into a burst mode with no gaps at all.
  poll_t       live_poll;
  int unsigned send_wait = 0;
  logic        send_burst = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      dial_bus.valid <= 1'b0;
      send_wait      <= 0;
    end else begin
      if (dial_bus.valid && dial_bus.ready)
        steer_from_poll(live_poll);
      if ($urandom_range(0, 39) == 0)
        send_burst <= ~send_burst;
      // The channel is free once the current poll has transferred or when
      // nothing is offered; only then may the next poll go out.
      if (!dial_bus.valid || dial_bus.ready) begin
        if (send_wait != 0) begin
          dial_bus.valid <= 1'b0;
          send_wait      <= send_wait - 1;
        end else if (poll_queue.size() != 0) begin
          live_poll = poll_queue.pop_front();
          dial_bus.dial_count   <= live_poll.dial_count;
          dial_bus.time_ms      <= live_poll.time_ms;
          dial_bus.fire_pressed <= live_poll.fire_pressed;
          dial_bus.game_running <= live_poll.game_running;
          dial_bus.valid        <= 1'b1;
          send_wait             <= send_burst ? 0 : $urandom_range(0, 14);
        end else begin
          dial_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver side. After every transfer ready drops for a drawn number of
  // cycles, again with occasional bursts where it stays high.
  int unsigned take_wait = 0;
  int unsigned take_gap;
  logic        take_burst = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      joy_bus.ready <= 1'b0;
      take_wait     <= 3;
    end else begin
      if ($urandom_range(0, 39) == 0)
        take_burst <= ~take_burst;
      if (joy_bus.valid && joy_bus.ready) begin
        check_joystick(joy_bus.port_value, joy_bus.steering);
        take_gap = take_burst ? 0 : $urandom_range(0, 14);
        joy_bus.ready <= (take_gap == 0);
        take_wait     <= take_gap;
      end else if (!joy_bus.ready) begin
        if (take_wait <= 1)
          joy_bus.ready <= 1'b1;
        if (take_wait != 0)
          take_wait <= take_wait - 1;
      end
    end
  end

  task automatic queue_poll(input logic [7:0] c, input logic [31:0] t,
                            input logic f, input logic g);
    poll_t p;
    p.dial_count   = c;
    p.time_ms      = t;
    p.fire_pressed = f;
    p.game_running = g;
    poll_queue.push_back(p);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
  endtask

  // Writes all five registers and keeps our copy in step with them.
  task automatic apply_setting(input logic rev, input logic [4:0] sens,
                               input logic [7:0] spawn, input logic [7:0] offs,
                               input logic [15:0] win);
    write_reg(REG_REVERSE, {15'd0, rev});
    write_reg(REG_SENSITIVITY, {11'd0, sens});
    write_reg(REG_SPAWN, {8'd0, spawn});
    write_reg(REG_OFFSET, {8'd0, offs});
    write_reg(REG_IDLE_WINDOW, win);
    @(posedge clk);
    wr_en <= 1'b0;
    cfg_reverse = rev;
    cfg_sens    = sens;
    cfg_spawn   = spawn;
    cfg_offset  = offs;
    cfg_window  = win;
  endtask

  // Waits until every poll has been answered, then lets a full divide's
  // worth of cycles pass so the block is certainly idle.
  task automatic wait_drained();
    while (poll_queue.size() != 0 || pending_joystick.size() != 0 || dial_bus.valid)
      @(posedge clk);
    repeat (ACC_BITS + 8) @(posedge clk);
  endtask

  function automatic int pick_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20)
      return 0;
    if (r < 50)
      return $urandom_range(0, 1) ? int'($urandom_range(1, 4)) : -int'($urandom_range(1, 4));
    if (r < 60) begin
      r = $urandom_range(0, 2);
      return (r == 0) ? 127 : (r == 1) ? -127 : -128;
    end
    return int'($urandom_range(0, 255)) - 128;
  endfunction

  // One random phase. Most polls are plausible dial motion inside or just
  // around the idle window; the rest are long pauses, jumps to arbitrary
  // counts and times, and times just short of the 32-bit wrap. A spin phase
  // turns hard one way to build up a large turn count.
  task automatic run_phase(input int n, input bit spin);
    int          step;
    int unsigned dt;
    int unsigned kind;
    int unsigned win;
    int          spin_sign;
    spin_sign = $urandom_range(0, 1) ? 1 : -1;
    win = 32'(cfg_window);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (spin) begin
        step = spin_sign * int'($urandom_range(100, 127));
        dt   = $urandom_range(0, 50);
      end else if (kind < 68) begin
        step = pick_step();
        dt   = $urandom_range(0, win + win / 4 + 1);
      end else if (kind < 74) begin
        step = pick_step();
        dt   = $urandom_range(0, 1) ? win : win + 1;
      end else if (kind < 86) begin
        step = 0;
        dt   = win + 1 + $urandom_range(0, 2000);
      end else if (kind < 95) begin
        step      = 0;
        dt        = 0;
        cur_count = 8'($urandom());
        cur_time  = $urandom();
      end else begin
        step     = pick_step();
        dt       = 0;
        cur_time = 32'hFFFF_FF00 | $urandom_range(0, 255);
      end
      cur_count = cur_count + step[7:0];
      cur_time  = cur_time + dt;
      queue_poll(cur_count, cur_time, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    dial_bus.valid        = 1'b0;
    dial_bus.dial_count   = '0;
    dial_bus.time_ms      = '0;
    dial_bus.fire_pressed = 1'b0;
    dial_bus.game_running = 1'b0;
    joy_bus.ready         = 1'b0;
    wr_en                 = 1'b0;
    wr_index              = '0;
    wr_data               = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed polls under the reset settings. The first poll only primes
    // the history, so fire is the only thing it can show.
    queue_poll(8'd200, 32'd1000, 1'b1, 1'b1);
    queue_poll(8'd200, 32'd1001, 1'b1, 1'b0);
    queue_poll(8'd201, 32'd1002, 1'b0, 1'b1);
    // Largest forward step, largest backward step, then the -128 step.
    queue_poll(8'd72, 32'd1003, 1'b1, 1'b1);
    queue_poll(8'd201, 32'd1004, 1'b0, 1'b0);
    queue_poll(8'd73, 32'd1005, 1'b0, 1'b1);
    // Right at the edge of the idle window, then one past it.
    queue_poll(8'd73, 32'd1095, 1'b1, 1'b1);
    queue_poll(8'd73, 32'd1096, 1'b0, 1'b1);
    // A step just before the millisecond clock wraps, then polls after it.
    queue_poll(8'd74, 32'hFFFF_FFF0, 1'b0, 1'b0);
    queue_poll(8'd74, 32'h0000_0010, 1'b1, 1'b1);
    queue_poll(8'd74, 32'h0000_0049, 1'b0, 1'b1);
    queue_poll(8'd255, 32'h0000_004A, 1'b0, 1'b1);
    // The count wraps from 255 to 0: a step of one, not of -255.
    queue_poll(8'd0, 32'h0000_004A, 1'b1, 1'b0);
    wait_drained();

    // Reversed, zero sensitivity, top spawn and offset, zero window: only a
    // poll at the very millisecond of the last step may steer.
    apply_setting(1'b1, 5'd0, 8'd255, 8'd255, 16'd0);
    queue_poll(8'd10, 32'd5000, 1'b0, 1'b1);
    queue_poll(8'd10, 32'd5000, 1'b1, 1'b1);
    queue_poll(8'd10, 32'd5001, 1'b0, 1'b0);
    queue_poll(8'd9, 32'd5001, 1'b1, 1'b1);
    wait_drained();

    // Largest sensitivity and the widest window, across the clock wrap.
    apply_setting(1'b0, 5'd31, 8'd0, 8'd0, 16'hFFFF);
    queue_poll(8'd100, 32'hFFFF_FFFF, 1'b0, 1'b1);
    queue_poll(8'd100, 32'h0000_FFFE, 1'b1, 1'b1);
    queue_poll(8'd100, 32'h0000_FFFF, 1'b0, 1'b1);
    queue_poll(8'd227, 32'h8000_0000, 1'b1, 1'b0);
    queue_poll(8'd99, 32'h8000_0000, 1'b0, 1'b1);
    wait_drained();

    cur_count = 8'd99;
    cur_time  = 32'h8000_0000;

    apply_setting(1'b0, 5'd1, 8'd0, 8'd0, 16'd0);
    run_phase(180, 1'b0);
    wait_drained();

    apply_setting(1'b1, 5'd16, 8'd255, 8'd255, 16'hFFFF);
    run_phase(180, 1'b0);
    wait_drained();

    apply_setting(1'b0, 5'd31, 8'($urandom()), 8'($urandom()), 16'($urandom()));
    run_phase(180, 1'b0);
    wait_drained();

    apply_setting(1'b1, 5'd0, 8'($urandom()), 8'($urandom()),
                  16'($urandom_range(0, 400)));
    run_phase(180, 1'b0);
    wait_drained();

    apply_setting(1'($urandom()), 5'($urandom_range(1, 16)), 8'($urandom()),
                  8'($urandom()), 16'hFFFF);
    run_phase(170, 1'b1);
    wait_drained();

    repeat (3) begin
      apply_setting(1'($urandom()), 5'($urandom_range(0, 31)), 8'($urandom()),
                    8'($urandom()),
                    $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : 16'($urandom()));
      run_phase(180, 1'b0);
      wait_drained();
    end

    apply_setting(1'b0, SENSITIVITY_RESET, SPAWN_RESET, OFFSET_RESET, IDLE_WINDOW_RESET);
    run_phase(100, 1'b0);
    wait_drained();

    if (mismatch_count == 0)
      $display("rotary_dial_to_eight_way_joystick verification clean");
    else
      $display("rotary_dial_to_eight_way_joystick verification failed");
    $finish;
  end

  // A run that stops answering would otherwise hang forever.
  initial begin
    #1000000;
    $display("rotary_dial_to_eight_way_joystick verification failed");
    $finish;
  end

endmodule
